// ----- rtl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg - shared definitions for the text console cursor/scroll core
// Field widths, character codes, result kinds and controller/datapath types.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int MAX_COLS_DEF = 160;
  localparam int MAX_ROWS_DEF = 96;

  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 8;
  localparam int GLYPH_W = 7;
  localparam int COLOR_W = 32;
  localparam int KIND_W  = 2;

  localparam int TD_ROW_LSB   = 0;
  localparam int TD_COL_LSB   = TD_ROW_LSB + ROW_W;
  localparam int TD_GLYPH_LSB = TD_COL_LSB + COL_W;
  localparam int TD_COLOR_LSB = TD_GLYPH_LSB + GLYPH_W;
  localparam int TD_USED_W    = TD_COLOR_LSB + COLOR_W;
  localparam int M_TDATA_W    = ((TD_USED_W + 7) / 8) * 8;
  localparam int S_TDATA_W    = CHAR_W;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TILDE     = 8'd126;
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 7'd32;
  localparam int TAB_WIDTH = 4;
  localparam int TAB_CNT_W = $clog2(TAB_WIDTH);

  localparam logic [7:0]         COLUMNS_RST = 8'd160;
  localparam logic [6:0]         ROWS_RST    = 7'd96;
  localparam logic [COLOR_W-1:0] COLOR_RST   = 32'd12632256;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_COLOR   = 2'd2,
    REG_ENABLE  = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CELL   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CC_NEWLINE,
    CC_RETURN,
    CC_BACKSPACE,
    CC_TAB,
    CC_PRINT,
    CC_OTHER
  } ch_class_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_TROW_MOD,
    OP_NEWLINE,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_CHAR,
    OP_PHYS,
    OP_PRINT_NEXT,
    OP_SCROLL,
    OP_HOME
  } dp_op_t;

  typedef enum logic [1:0] {
    ADDR_CUR,
    ADDR_ROW,
    ADDR_ALL
  } addr_sel_t;

  typedef enum logic [1:0] {
    EMIT_PRINT,
    EMIT_BS,
    EMIT_SCROLL,
    EMIT_CLEAR
  } emit_src_t;

  typedef struct packed {
    dp_op_t    op;
    logic      mod_start;
    logic      sweep_clr;
    logic      sweep_inc;
    logic      ram_we;
    addr_sel_t addr_sel;
    logic      emit;
    emit_src_t emit_src;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic      enabled;
    logic      is_clear;
    ch_class_t ch_class;
    logic      top_lt_rows;
    logic      mod_done;
    logic      col_full;
    logic      row_has_next;
    logic      row_sweep_done;
    logic      all_sweep_done;
    logic      tab_more;
    logic      out_free;
  } dp_status_t;

endpackage

// ----- rtl/tcc_ram.sv -----
// ----------------------------------------------------------------------------
// tcc_ram - generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/tcc_mod.sv -----
// ----------------------------------------------------------------------------
// tcc_mod - iterative remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tcc_mod #(
  parameter int W = 7,
  localparam int CNT_W = $clog2(W + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);

  logic [W-1:0]     shreg;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       trial;

  assign trial = {rem, shreg[W-1]};
  assign done  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(W);
    end else if (!done) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (!done) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= W'(trial - {1'b0, divisor});
      end else begin
        rem <= W'(trial);
      end
    end
  end

endmodule

// ----- rtl/tcc_dp.sv -----
// ----------------------------------------------------------------------------
// tcc_dp - console datapath
// Cursor, scroll offset, ring row mapping, color store and result register.
// ----------------------------------------------------------------------------
module tcc_dp import tcc_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         columns,
  input  logic [6:0]         rows_in_use,
  input  logic [COLOR_W-1:0] text_color,
  input  logic               enabled,
  input  logic               in_action,
  input  logic [CHAR_W-1:0]  in_char,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic               out_valid,
  input  logic               out_ready,
  output kind_t              out_kind,
  output logic [ROW_W-1:0]   out_row,
  output logic [COL_W-1:0]   out_col,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_last
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [CW-1:0]        cols_eff;
  logic [RW-1:0]        rows_eff;
  logic [RW-1:0]        cur_row;
  logic [CW-1:0]        cur_col;
  logic [RW-1:0]        top;
  logic [RW-1:0]        trow;
  logic [RW-1:0]        trow_next;
  logic [RW:0]          trow_inc;
  logic [RW-1:0]        phys;
  logic [RW-1:0]        phys_next;
  logic [RW:0]          phys_sum;
  logic [AW-1:0]        sweep;
  logic [AW-1:0]        row_base;
  logic [AW-1:0]        ram_addr;
  logic [COLOR_W-1:0]   ram_rdata;
  logic                 act_q;
  logic [CHAR_W-1:0]    ch_q;
  logic [GLYPH_W-1:0]   glyph_q;
  logic [TAB_CNT_W-1:0] tab_cnt;
  logic                 mod_done;
  logic [RW-1:0]        mod_rem;
  logic                 row_has_next;
  ch_class_t            ch_class;

  always_comb begin
    if (columns == '0) begin
      cols_eff = CW'(1);
    end else if (int'(columns) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(columns);
    end
    if (rows_in_use == '0) begin
      rows_eff = RW'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_in_use);
    end
  end

  always_comb begin
    if (ch_q == CH_NEWLINE) begin
      ch_class = CC_NEWLINE;
    end else if (ch_q == CH_RETURN) begin
      ch_class = CC_RETURN;
    end else if (ch_q == CH_BACKSPACE) begin
      ch_class = CC_BACKSPACE;
    end else if (ch_q == CH_TAB) begin
      ch_class = CC_TAB;
    end else if (ch_q >= CH_SPACE && ch_q <= CH_TILDE) begin
      ch_class = CC_PRINT;
    end else begin
      ch_class = CC_OTHER;
    end
  end

  assign row_has_next = ({1'b0, cur_row} + (RW+1)'(1)) < {1'b0, rows_eff};

  // ring mapping: trow < rows and cur_row < rows, so one subtract wraps
  assign phys_sum  = {1'b0, trow} + {1'b0, cur_row};
  assign phys_next = (phys_sum >= {1'b0, rows_eff}) ?
                     RW'(phys_sum - {1'b0, rows_eff}) : RW'(phys_sum);
  assign trow_inc  = {1'b0, trow} + (RW+1)'(1);
  assign trow_next = (trow_inc == {1'b0, rows_eff}) ? '0 : RW'(trow_inc);

  tcc_mod #(.W(RW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (top),
    .divisor  (rows_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign row_base = AW'(phys) * AW'(MAX_COLS);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_CUR: ram_addr = row_base + AW'(cur_col);
      ADDR_ROW: ram_addr = row_base + sweep;
      ADDR_ALL: ram_addr = sweep;
      default:  ram_addr = row_base + AW'(cur_col);
    endcase
  end

  tcc_ram #(.WIDTH(COLOR_W), .DEPTH(CELLS)) u_color (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (text_color),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      top     <= '0;
      trow    <= '0;
    end else begin
      case (cmd.op)
        OP_PREP: begin
          if (cur_row >= rows_eff) begin
            cur_row <= rows_eff - RW'(1);
          end
          if (cur_col > cols_eff) begin
            cur_col <= cols_eff;
          end
          if (top < rows_eff) begin
            trow <= top;
          end
        end
        OP_TROW_MOD: trow <= mod_rem;
        OP_NEWLINE: begin
          cur_col <= '0;
          if (row_has_next) begin
            cur_row <= cur_row + RW'(1);
          end
        end
        OP_CR: cur_col <= '0;
        OP_BS: begin
          if (cur_col != '0) begin
            cur_col <= cur_col - CW'(1);
          end else if (cur_row != '0) begin
            cur_row <= cur_row - RW'(1);
            cur_col <= cols_eff - CW'(1);
          end
        end
        OP_PRINT_NEXT: cur_col <= cur_col + CW'(1);
        OP_SCROLL: begin
          top     <= trow_next;
          trow    <= trow_next;
          cur_row <= rows_eff - RW'(1);
        end
        OP_HOME: begin
          cur_row <= '0;
          cur_col <= '0;
          top     <= '0;
          trow    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_q <= in_action;
        ch_q  <= in_char;
      end
      OP_TAB: begin
        glyph_q <= GLYPH_BLANK;
        tab_cnt <= TAB_CNT_W'(TAB_WIDTH - 1);
      end
      OP_CHAR: begin
        glyph_q <= ch_q[GLYPH_W-1:0];
        tab_cnt <= '0;
      end
      OP_PRINT_NEXT: begin
        if (tab_cnt != '0) begin
          tab_cnt <= tab_cnt - TAB_CNT_W'(1);
        end
      end
      OP_PHYS: phys <= phys_next;
      default: ;
    endcase
    if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_inc) begin
      sweep <= sweep + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      case (cmd.emit_src)
        EMIT_PRINT: begin
          out_kind  <= KIND_CELL;
          out_row   <= ROW_W'(cur_row);
          out_col   <= COL_W'(cur_col);
          out_glyph <= glyph_q;
          out_color <= text_color;
        end
        EMIT_BS: begin
          out_kind  <= KIND_CELL;
          out_row   <= ROW_W'(cur_row);
          out_col   <= COL_W'(cur_col);
          out_glyph <= GLYPH_BLANK;
          out_color <= ram_rdata;
        end
        EMIT_SCROLL: begin
          out_kind  <= KIND_SCROLL;
          out_row   <= ROW_W'(rows_eff - RW'(1));
          out_col   <= '0;
          out_glyph <= GLYPH_BLANK;
          out_color <= text_color;
        end
        default: begin
          out_kind  <= KIND_CLEAR;
          out_row   <= '0;
          out_col   <= '0;
          out_glyph <= GLYPH_BLANK;
          out_color <= text_color;
        end
      endcase
    end
  end

  always_comb begin
    status.enabled        = enabled;
    status.is_clear       = act_q;
    status.ch_class       = ch_class;
    status.top_lt_rows    = (top < rows_eff);
    status.mod_done       = mod_done;
    status.col_full       = (cur_col >= cols_eff);
    status.row_has_next   = row_has_next;
    status.row_sweep_done = (int'(sweep) == int'(cols_eff) - 1);
    status.all_sweep_done = (int'(sweep) == CELLS - 1);
    status.tab_more       = (tab_cnt != '0);
    status.out_free       = !out_valid || out_ready;
  end

endmodule

// ----- rtl/tcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcc_ctrl - console controller
// Sequences one request at a time through the datapath: decode, cursor moves,
// row scrolls, full clears and result emission.
// ----------------------------------------------------------------------------
module tcc_ctrl import tcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PREP  = 16'h0002,
    S_MOD   = 16'h0004,
    S_DISP  = 16'h0008,
    S_PRINT = 16'h0010,
    S_PPHYS = 16'h0020,
    S_PEMIT = 16'h0040,
    S_SCRL  = 16'h0080,
    S_SPHYS = 16'h0100,
    S_SSWP  = 16'h0200,
    S_SEMIT = 16'h0400,
    S_BPHYS = 16'h0800,
    S_BREAD = 16'h1000,
    S_BEMIT = 16'h2000,
    S_CLR   = 16'h4000,
    S_CEMIT = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   from_print, from_print_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      from_print <= 1'b0;
    end else begin
      state      <= state_next;
      from_print <= from_print_next;
    end
  end

  always_comb begin
    state_next      = state;
    from_print_next = from_print;
    cmd             = '0;
    cmd.addr_sel    = ADDR_CUR;
    case (state)
      S_IDLE: begin
        if (in_valid && status.enabled) begin
          cmd.op     = OP_LOAD;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op = OP_PREP;
        if (status.top_lt_rows) begin
          state_next = S_DISP;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        if (status.mod_done) begin
          cmd.op     = OP_TROW_MOD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.is_clear) begin
          cmd.sweep_clr = 1'b1;
          state_next    = S_CLR;
        end else begin
          case (status.ch_class)
            CC_NEWLINE: begin
              cmd.op = OP_NEWLINE;
              if (status.row_has_next) begin
                state_next = S_IDLE;
              end else begin
                from_print_next = 1'b0;
                state_next      = S_SCRL;
              end
            end
            CC_RETURN: begin
              cmd.op     = OP_CR;
              state_next = S_IDLE;
            end
            CC_BACKSPACE: begin
              cmd.op     = OP_BS;
              state_next = S_BPHYS;
            end
            CC_TAB: begin
              cmd.op     = OP_TAB;
              state_next = S_PRINT;
            end
            CC_PRINT: begin
              cmd.op     = OP_CHAR;
              state_next = S_PRINT;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PRINT: begin
        if (status.col_full) begin
          cmd.op = OP_NEWLINE;
          if (status.row_has_next) begin
            state_next = S_PPHYS;
          end else begin
            from_print_next = 1'b1;
            state_next      = S_SCRL;
          end
        end else begin
          state_next = S_PPHYS;
        end
      end
      S_PPHYS: begin
        cmd.op     = OP_PHYS;
        state_next = S_PEMIT;
      end
      S_PEMIT: begin
        if (status.out_free) begin
          cmd.ram_we    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_src  = EMIT_PRINT;
          cmd.emit_last = !status.tab_more;
          cmd.op        = OP_PRINT_NEXT;
          state_next    = status.tab_more ? S_PRINT : S_IDLE;
        end
      end
      S_SCRL: begin
        cmd.op        = OP_SCROLL;
        cmd.sweep_clr = 1'b1;
        state_next    = S_SPHYS;
      end
      S_SPHYS: begin
        cmd.op     = OP_PHYS;
        state_next = S_SSWP;
      end
      S_SSWP: begin
        cmd.ram_we    = 1'b1;
        cmd.addr_sel  = ADDR_ROW;
        cmd.sweep_inc = 1'b1;
        if (status.row_sweep_done) begin
          state_next = S_SEMIT;
        end
      end
      S_SEMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = EMIT_SCROLL;
          cmd.emit_last = !from_print;
          state_next    = from_print ? S_PPHYS : S_IDLE;
        end
      end
      S_BPHYS: begin
        cmd.op     = OP_PHYS;
        state_next = S_BREAD;
      end
      S_BREAD: state_next = S_BEMIT;
      S_BEMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = EMIT_BS;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.ram_we    = 1'b1;
        cmd.addr_sel  = ADDR_ALL;
        cmd.sweep_inc = 1'b1;
        if (status.all_sweep_done) begin
          cmd.op     = OP_HOME;
          state_next = S_CEMIT;
        end
      end
      S_CEMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = EMIT_CLEAR;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/text_console_cursor_scroll_core.sv -----
// A printable byte passes the prep, dispatch, print, physical-row and emit states
//   before its result is registered; the remainder unit adds a pass when the scroll
//   offset lies beyond a shrunk row count, and each scroll adds a row blanking sweep.
// One request at a time: s_tready is high only while idle; a clear sweeps all
//   MAX_ROWS * MAX_COLS cells (full sweep); result stalls hold each request.
// Reset: cursor, offset and config go to defaults; cell colors stay undefined until
//   a clear, a print or a row scroll writes them (no clearing pass).
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core - character-cell console engine
// Stream in characters or clear requests, stream out cell/scroll/clear results.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core import tcc_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code
  input  logic                 s_tuser,   // [0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // cell_row, cell_col, glyph, glyph_color
  output logic [KIND_W-1:0]    m_tuser,   // [1:0] kind
  output logic                 m_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [7:0]         columns;
  logic [6:0]         rows_in_use;
  logic [COLOR_W-1:0] text_color;
  logic               enabled;
  logic               cfg_wr;
  reg_idx_t           reg_idx;
  dp_cmd_t            cmd;
  dp_status_t         status;
  kind_t              out_kind;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic [GLYPH_W-1:0] out_glyph;
  logic [COLOR_W-1:0] out_color;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      columns     <= COLUMNS_RST;
      rows_in_use <= ROWS_RST;
      text_color  <= COLOR_RST;
      enabled     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COLUMNS: columns     <= pwdata[7:0];
        REG_ROWS:    rows_in_use <= pwdata[6:0];
        REG_COLOR:   text_color  <= pwdata;
        REG_ENABLE:  enabled     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLUMNS: prdata = {24'd0, columns};
      REG_ROWS:    prdata = {25'd0, rows_in_use};
      REG_COLOR:   prdata = text_color;
      REG_ENABLE:  prdata = {31'd0, enabled};
      default:     prdata = '0;
    endcase
  end

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tcc_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .columns     (columns),
    .rows_in_use (rows_in_use),
    .text_color  (text_color),
    .enabled     (enabled),
    .in_action   (s_tuser),
    .in_char     (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (out_kind),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_glyph   (out_glyph),
    .out_color   (out_color),
    .out_last    (m_tlast)
  );

  assign m_tdata = {(M_TDATA_W - TD_USED_W)'(0), out_color, out_glyph, out_col, out_row};
  assign m_tuser = out_kind;

endmodule

// ----- rtl/tcc_checker.sv -----
// ----------------------------------------------------------------------------
// tcc_checker - port-level checks for the console core
// Result stream stability, scroll/clear fixed fields and printable cell glyphs.
// ----------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]    m_tuser,
  input logic                 m_tlast
);

  logic [ROW_W-1:0]   row_f;
  logic [COL_W-1:0]   col_f;
  logic [GLYPH_W-1:0] glyph_f;

  assign row_f   = m_tdata[TD_ROW_LSB +: ROW_W];
  assign col_f   = m_tdata[TD_COL_LSB +: COL_W];
  assign glyph_f = m_tdata[TD_GLYPH_LSB +: GLYPH_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CLEAR |->
      m_tlast && row_f == '0 && col_f == '0 && glyph_f == GLYPH_BLANK)
    else $error("bad clear result");

  a_scroll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SCROLL |-> col_f == '0 && glyph_f == GLYPH_BLANK)
    else $error("bad scroll result");

  a_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CELL |->
      {1'b0, glyph_f} >= CH_SPACE && {1'b0, glyph_f} <= CH_TILDE)
    else $error("cell result holds a non-printable glyph");

endmodule

bind text_console_cursor_scroll_core tcc_checker u_tcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- bench/text_console_cursor_scroll_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core_test - console engine self-checking bench
// Streams characters and clear requests through the core under random source
// and sink gaps. An in-bench grid/cursor/offset model predicts every cell,
// scroll and clear result, which is checked field by field against m_* beats.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core_test;
  import tcc_pkg::*;

  localparam int CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;

  typedef struct packed {
    kind_t        kind;
    logic [6:0]   row;
    logic [7:0]   col;
    logic [6:0]   glyph;
    logic [31:0]  color;
    logic         last;
  } cell_event_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // [7:0] char_code
  logic                 s_tuser = 1'b0; // [0] action
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // cell_row, cell_col, glyph, glyph_color
  logic [KIND_W-1:0]    m_tuser;        // [1:0] kind
  logic                 m_tlast;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // console model state
  logic [6:0]   glyph_mem [CELLS];
  logic [31:0]  color_mem [CELLS];
  int unsigned  cur_row = 0, cur_col = 0, top_off = 0;
  logic [7:0]   cfg_cols = COLUMNS_RST;
  logic [6:0]   cfg_rows = ROWS_RST;
  logic [31:0]  cfg_color = COLOR_RST;
  logic         cfg_en = 1'b0;

  cell_event_t  step_buf[$];
  cell_event_t  pending_q[$];
  cell_event_t  want;

  int unsigned  req_cnt = 0, result_cnt = 0, clear_cnt = 0, err_cnt = 0;
  bit           src_gaps_on = 1'b1;
  bit           sink_gaps_on = 1'b1;
  int unsigned  sink_hold = 0;

  text_console_cursor_scroll_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic int unsigned eff_cols();
    if (cfg_cols == 0) return 1;
    return (cfg_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cfg_cols;
  endfunction

  function automatic int unsigned eff_rows();
    if (cfg_rows == 0) return 1;
    return (cfg_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : cfg_rows;
  endfunction

  function automatic int unsigned cell_at(input int unsigned row, input int unsigned col);
    int unsigned phys;
    phys = (top_off % MAX_ROWS_DEF + row) % eff_rows();
    return (phys * MAX_COLS_DEF + col) % CELLS;
  endfunction

  function automatic void note_event(input kind_t k, input int unsigned row,
                                     input int unsigned col, input logic [6:0] g,
                                     input logic [31:0] color);
    cell_event_t ev;
    ev.kind  = k;
    ev.row   = row[6:0];
    ev.col   = col[7:0];
    ev.glyph = g;
    ev.color = color;
    ev.last  = 1'b0;
    step_buf.push_back(ev);
  endfunction

  function automatic void roll_up();
    int unsigned rows, cols, c, idx;
    rows = eff_rows();
    cols = eff_cols();
    top_off = (top_off % rows + 1) % rows;
    for (c = 0; c < cols; c++) begin
      idx = cell_at(rows - 1, c);
      glyph_mem[idx] = GLYPH_BLANK;
      color_mem[idx] = cfg_color;
    end
    cur_row = rows - 1;
    note_event(KIND_SCROLL, rows - 1, 0, GLYPH_BLANK, cfg_color);
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    if (cur_row + 1 < eff_rows()) cur_row++;
    else roll_up();
  endfunction

  function automatic void put_glyph(input logic [6:0] g);
    int unsigned idx;
    if (cur_col >= eff_cols()) line_feed();
    idx = cell_at(cur_row, cur_col);
    glyph_mem[idx] = g;
    color_mem[idx] = cfg_color;
    note_event(KIND_CELL, cur_row, cur_col, g, cfg_color);
    cur_col++;
  endfunction

  function automatic void apply_request(input logic act, input logic [7:0] code);
    int unsigned rows, cols, idx, k;
    cell_event_t ev;
    step_buf.delete();
    if (!cfg_en) return;
    rows = eff_rows();
    cols = eff_cols();
    if (cur_row >= rows) cur_row = rows - 1;
    if (cur_col > cols) cur_col = cols;
    if (act) begin
      for (k = 0; k < CELLS; k++) begin
        glyph_mem[k] = GLYPH_BLANK;
        color_mem[k] = cfg_color;
      end
      cur_row = 0;
      cur_col = 0;
      top_off = 0;
      clear_cnt++;
      note_event(KIND_CLEAR, 0, 0, GLYPH_BLANK, cfg_color);
    end else if (code == CH_NEWLINE) begin
      line_feed();
    end else if (code == CH_RETURN) begin
      cur_col = 0;
    end else if (code == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = cols - 1;
      end
      idx = cell_at(cur_row, cur_col);
      glyph_mem[idx] = GLYPH_BLANK;
      note_event(KIND_CELL, cur_row, cur_col, GLYPH_BLANK, color_mem[idx]);
    end else if (code == CH_TAB) begin
      for (k = 0; k < TAB_WIDTH; k++) put_glyph(GLYPH_BLANK);
    end else if (code >= CH_SPACE && code <= CH_TILDE) begin
      put_glyph(code[6:0]);
    end
    for (k = 0; k < step_buf.size(); k++) begin
      ev = step_buf[k];
      ev.last = (k == step_buf.size() - 1);
      pending_q.push_back(ev);
    end
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(input logic act, input logic [7:0] code);
    int unsigned gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(act, code);
    req_cnt++;
  endtask

  task automatic send_char(input logic [7:0] code);
    send_req(1'b0, code);
  endtask

  task automatic send_random();
    int unsigned r;
    logic [7:0] code;
    r = $urandom_range(0, 999);
    code = 8'($urandom_range(0, 255));
    if (r < 12) send_req(1'b1, code);
    else if (r < 600) send_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
    else if (r < 700) send_char(CH_NEWLINE);
    else if (r < 760) send_char(CH_RETURN);
    else if (r < 850) send_char(CH_BACKSPACE);
    else if (r < 900) send_char(CH_TAB);
    else send_char(code);
  endtask

  // wait out all results, then the tail of any request that gives none
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] stored;
    case (idx)
      REG_COLUMNS: stored = {24'd0, val[7:0]};
      REG_ROWS:    stored = {25'd0, val[6:0]};
      REG_COLOR:   stored = val;
      default:     stored = {31'd0, val[0]};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_COLUMNS: cfg_cols = val[7:0];
      REG_ROWS:    cfg_rows = val[6:0];
      REG_COLOR:   cfg_color = val;
      default:     cfg_en = val[0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) begin
      $error("register %0d readback mismatch: expected %h, actual %h", idx, stored, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_console(input logic [7:0] cols, input logic [6:0] rows,
                             input logic [31:0] color, input logic en);
    write_reg(REG_COLUMNS, {24'd0, cols});
    write_reg(REG_ROWS, {25'd0, rows});
    write_reg(REG_COLOR, color);
    write_reg(REG_ENABLE, {31'd0, en});
  endtask

  // ---------------------------------------------------------------- sink
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_cnt++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h last %0d", m_tuser, m_tdata, m_tlast);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
          err_cnt++;
        end
        if (m_tdata[TD_ROW_LSB +: ROW_W] !== want.row) begin
          $error("cell_row mismatch: expected %0d, actual %0d", want.row,
                 m_tdata[TD_ROW_LSB +: ROW_W]);
          err_cnt++;
        end
        if (m_tdata[TD_COL_LSB +: COL_W] !== want.col) begin
          $error("cell_col mismatch: expected %0d, actual %0d", want.col,
                 m_tdata[TD_COL_LSB +: COL_W]);
          err_cnt++;
        end
        if (m_tdata[TD_GLYPH_LSB +: GLYPH_W] !== want.glyph) begin
          $error("glyph mismatch: expected %0d, actual %0d", want.glyph,
                 m_tdata[TD_GLYPH_LSB +: GLYPH_W]);
          err_cnt++;
        end
        if (m_tdata[TD_COLOR_LSB +: COLOR_W] !== want.color) begin
          $error("glyph_color mismatch: expected %h, actual %h", want.color,
                 m_tdata[TD_COLOR_LSB +: COLOR_W]);
          err_cnt++;
        end
        if (m_tlast !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_disabled();
    send_req(1'b1, 8'h00);
    send_char(CH_BACKSPACE);
    send_char("A");
    send_char(CH_TAB);
    send_char(CH_NEWLINE);
    send_char(8'hFF);
    settle();
  endtask

  task automatic test_directed();
    logic [31:0] first_color;
    first_color = $urandom;
    set_console(8'd4, 7'd3, first_color, 1'b1);
    send_req(1'b1, 8'hFF);
    send_char(CH_BACKSPACE);          // at home
    send_char(CH_SPACE);
    send_char(CH_TILDE);
    send_char("A");
    send_char("z");                   // rests past the last column
    send_char(CH_BACKSPACE);
    send_char("x");
    send_char("y");                   // deferred wrap
    send_char(CH_NEWLINE);
    send_char(CH_NEWLINE);            // scroll at bottom
    send_char(CH_TAB);
    send_char(CH_TAB);                // wrap and scroll inside a tab
    send_char(CH_RETURN);
    send_char(CH_BACKSPACE);          // back onto the row above
    send_char(8'h00);
    send_char(8'h7F);
    send_char(8'hFF);
    send_char(8'h1F);
    send_char(8'h80);
    settle();
    write_reg(REG_COLOR, ~first_color);
    send_char(CH_BACKSPACE);          // keeps the old cell color
    send_req(1'b1, 8'h00);
    settle();
  endtask

  task automatic test_shrink();
    int unsigned k;
    set_console(8'd12, 7'd6, $urandom, 1'b1);
    send_req(1'b1, 8'h5A);
    for (k = 0; k < 10; k++) send_char(CH_NEWLINE);
    for (k = 0; k < 10; k++) send_char("k");
    settle();
    // offset and cursor now lie beyond the smaller grid
    write_reg(REG_COLUMNS, 32'd4);
    write_reg(REG_ROWS, 32'd3);
    send_char("p");
    send_char(CH_BACKSPACE);
    send_char(CH_BACKSPACE);
    send_char(CH_BACKSPACE);
    send_char(CH_NEWLINE);
    send_char("q");
    send_char(CH_RETURN);
    send_char(CH_BACKSPACE);
    settle();
  endtask

  task automatic test_pressure();
    int unsigned k;
    set_console(8'd20, 7'd4, $urandom, 1'b1);
    src_gaps_on = 1'b0;
    sink_hold = 400;
    for (k = 0; k < 30; k++) send_random();
    settle();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned ph, k;
    logic [7:0] cols;
    logic [6:0] rows;
    logic [31:0] color;
    logic en;
    for (ph = 0; ph < 7; ph++) begin
      en = 1'b1;
      color = $urandom;
      case (ph)
        0: begin cols = 8'd1;   rows = 7'd1;   color = 32'h0000_0000; end
        1: begin cols = 8'd160; rows = 7'd96;  color = 32'hFFFF_FFFF; end
        2: begin cols = 8'd0;   rows = 7'd0;   end
        3: begin cols = 8'd255; rows = 7'd127; end
        4: begin cols = 8'd7;   rows = 7'd5;   en = 1'b0; end
        default: begin
          cols = 8'($urandom_range(1, 24));
          rows = 7'($urandom_range(1, 10));
        end
      endcase
      src_gaps_on  = (ph != 1);
      sink_gaps_on = (ph != 1);
      set_console(cols, rows, color, en);
      for (k = 0; k < 44; k++) send_random();
      settle();
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_shrink();
    test_pressure();
    test_random();
    settle();
    $display("Sent %0d requests (%0d clears), checked %0d results on grids from 1x1 to 160x96,",
             req_cnt, clear_cnt, result_cnt);
    $display("with disabled input, clamped and shrunken grids and a 400-cycle output stall.");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results still pending", pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
